// ===== rtl/dsdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdd_pkg
// Shared types and constants for the debounced setpoint deadband drive.
// ----------------------------------------------------------------------------
package dsdd_pkg;

  // debounce counter default width
  localparam int DSDD_COUNTER_BITS = 16;

  // configuration register widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TICKS_W     = 16;
  localparam int GAIN_W      = 7;
  localparam int POS_W       = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_GAIN      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_LOW      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_HIGH     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE      = 3'd4;

  // configuration reset values
  localparam logic [TICKS_W-1:0] RST_DEBOUNCE_TICKS = 16'd60;
  localparam logic [GAIN_W-1:0]  RST_STEP_GAIN      = 7'd1;
  localparam logic [POS_W-1:0]   RST_LIMIT_LOW      = 8'd5;
  localparam logic [POS_W-1:0]   RST_LIMIT_HIGH     = 8'd249;
  localparam logic [POS_W-1:0]   RST_TOLERANCE      = 8'd5;

  // setpoint after reset
  localparam logic [POS_W-1:0]   RST_SETPOINT       = 8'd128;

  // key debouncer phase
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_UP   = 2'd1,
    PH_WAIT_DOWN = 2'd2
  } key_phase_t;

  // accepted key step from the debouncer
  typedef struct packed {
    logic up;
    logic down;
  } step_t;

endpackage

// ===== rtl/dsdd_debounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdd_debounce
// Key debouncer: waits a configured number of ticks after a press and then
// samples the key again, giving one step per wait that ends with the key still held.
// ----------------------------------------------------------------------------
module dsdd_debounce
  import dsdd_pkg::*;
#(
  parameter int COUNTER_BITS = DSDD_COUNTER_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               key_up,
  input  logic               key_down,
  input  logic [TICKS_W-1:0] debounce_ticks,
  output step_t              step
);

  localparam int CMP_W = (COUNTER_BITS > TICKS_W) ? COUNTER_BITS : TICKS_W;

  key_phase_t              phase, phase_next;
  logic [COUNTER_BITS-1:0] wait_count, wait_count_next;
  logic [COUNTER_BITS-1:0] count_inc;
  logic                    both_held;
  logic                    waiting;
  logic                    done;

  // counter advances every tick and wraps
  assign count_inc = wait_count + COUNTER_BITS'(1);
  assign both_held = key_up && key_down;
  assign waiting   = (phase == PH_WAIT_UP) || (phase == PH_WAIT_DOWN);
  assign done      = waiting && (CMP_W'(count_inc) >= CMP_W'(debounce_ticks));

  // next phase and counter
  always_comb begin
    phase_next      = phase;
    wait_count_next = count_inc;
    if (both_held) begin
      phase_next = PH_IDLE;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (key_up) begin
            phase_next      = PH_WAIT_UP;
            wait_count_next = '0;
          end else if (key_down) begin
            phase_next      = PH_WAIT_DOWN;
            wait_count_next = '0;
          end
        end
        PH_WAIT_UP, PH_WAIT_DOWN: begin
          if (done) begin
            phase_next      = PH_IDLE;
            wait_count_next = '0;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // step once the wait is over and the awaited key is still held
  always_comb begin
    step.up   = !both_held && done && (phase == PH_WAIT_UP) && key_up;
    step.down = !both_held && done && (phase == PH_WAIT_DOWN) && key_down;
  end

  // state registers, one update per transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_count <= '0;
    end else if (en) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
    end
  end

endmodule

// ===== rtl/dsdd_setpoint.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdd_setpoint
// Setpoint register with saturating step, limit clamp and deadband drive
// decision against the measured position.
// ----------------------------------------------------------------------------
module dsdd_setpoint
  import dsdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  step_t             step,
  input  logic [GAIN_W-1:0] step_gain,
  input  logic [POS_W-1:0]  limit_low,
  input  logic [POS_W-1:0]  limit_high,
  input  logic [POS_W-1:0]  tolerance,
  input  logic [POS_W-1:0]  position,
  output logic [POS_W-1:0]  setpoint_next,
  output logic              drive_forward,
  output logic              drive_reverse
);

  logic [POS_W-1:0] setpoint;
  logic [POS_W+1:0] sum;
  logic [POS_W+1:0] base;
  logic [POS_W+1:0] gain_ext;
  logic [POS_W-1:0] sat;
  logic [POS_W:0]   pos_plus_tol;
  logic [POS_W:0]   sp_plus_tol;

  assign base     = {2'b00, setpoint};
  assign gain_ext = (POS_W + 2)'(step_gain);

  // step; sum is two's complement, top bit marks a negative result
  always_comb begin
    if (step.up) begin
      sum = base + gain_ext;
    end else if (step.down) begin
      sum = base - gain_ext;
    end else begin
      sum = base;
    end
  end

  // saturate to 0..255, then clamp with the low test first
  always_comb begin
    if (sum[POS_W+1]) begin
      sat = '0;
    end else if (sum[POS_W]) begin
      sat = '1;
    end else begin
      sat = sum[POS_W-1:0];
    end
    if (sat < limit_low) begin
      setpoint_next = limit_low;
    end else if (sat > limit_high) begin
      setpoint_next = limit_high;
    end else begin
      setpoint_next = sat;
    end
  end

  // deadband around the new setpoint
  assign pos_plus_tol  = {1'b0, position} + {1'b0, tolerance};
  assign sp_plus_tol   = {1'b0, setpoint_next} + {1'b0, tolerance};
  assign drive_forward = {1'b0, setpoint_next} > pos_plus_tol;
  assign drive_reverse = !drive_forward && ({1'b0, position} > sp_plus_tol);

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= RST_SETPOINT;
    end else if (en) begin
      setpoint <= setpoint_next;
    end
  end

endmodule

// ===== rtl/debounced_setpoint_deadband_drive_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_setpoint_deadband_drive_top
// Debounced up/down setpoint with an on/off deadband position drive.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one control tick: key_up,
//   key_down and the measured position. Output channel (out_valid/out_stall)
//   returns one result per tick: drive_forward, drive_reverse, setpoint_now.
//   A tick is taken into an input register, worked out combinationally and
//   written to the result register when it is free; a result is offered
//   once its tick has passed both registers. One tick per cycle is sustained
//   while the receiver does not stall; the setpoint, key phase and wait
//   counter update as a tick moves on. When the receiver stalls, the result
//   register holds and the input register still takes one more tick; after
//   that in_stall rises until the result is taken.
//   Reset (rst, synchronous) empties both registers, returns the debouncer to
//   idle, the setpoint to 128 and the configuration registers to defaults.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
//   next edge and are meant for when no tick is in flight.
// ----------------------------------------------------------------------------
module debounced_setpoint_deadband_drive_top
  import dsdd_pkg::*;
#(
  parameter int COUNTER_BITS = DSDD_COUNTER_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   key_up,
  input  logic                   key_down,
  input  logic [POS_W-1:0]       position,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   drive_forward,
  output logic                   drive_reverse,
  output logic [POS_W-1:0]       setpoint_now
);

  logic [TICKS_W-1:0] debounce_ticks;
  logic [GAIN_W-1:0]  step_gain;
  logic [POS_W-1:0]   limit_low;
  logic [POS_W-1:0]   limit_high;
  logic [POS_W-1:0]   tolerance;

  logic               in_full;
  logic               key_up_q;
  logic               key_down_q;
  logic [POS_W-1:0]   position_q;

  logic               in_take;
  logic               advance;
  step_t              step;
  logic [POS_W-1:0]   setpoint_next;
  logic               fwd_next;
  logic               rev_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= RST_DEBOUNCE_TICKS;
      step_gain      <= RST_STEP_GAIN;
      limit_low      <= RST_LIMIT_LOW;
      limit_high     <= RST_LIMIT_HIGH;
      tolerance      <= RST_TOLERANCE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data[TICKS_W-1:0];
        CFG_STEP_GAIN:      step_gain      <= cfg_data[GAIN_W-1:0];
        CFG_LIMIT_LOW:      limit_low      <= cfg_data[POS_W-1:0];
        CFG_LIMIT_HIGH:     limit_high     <= cfg_data[POS_W-1:0];
        CFG_TOLERANCE:      tolerance      <= cfg_data[POS_W-1:0];
        default: begin
          debounce_ticks <= debounce_ticks;
        end
      endcase
    end
  end

  // handshake: input register moves on when the result register is free
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      key_up_q   <= key_up;
      key_down_q <= key_down;
      position_q <= position;
    end
  end

  // key debouncer
  dsdd_debounce #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_debounce (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .key_up        (key_up_q),
    .key_down      (key_down_q),
    .debounce_ticks(debounce_ticks),
    .step          (step)
  );

  // setpoint and drive decision
  dsdd_setpoint u_setpoint (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .step         (step),
    .step_gain    (step_gain),
    .limit_low    (limit_low),
    .limit_high   (limit_high),
    .tolerance    (tolerance),
    .position     (position_q),
    .setpoint_next(setpoint_next),
    .drive_forward(fwd_next),
    .drive_reverse(rev_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_forward <= fwd_next;
      drive_reverse <= rev_next;
      setpoint_now  <= setpoint_next;
    end
  end

  // checks
  a_drive_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_forward && drive_reverse))
    else $error("forward and reverse driven together");

  a_step_single: assert property (@(posedge clk) disable iff (rst)
    advance |-> !(step.up && step.down))
    else $error("debouncer gave both steps");

  a_setpoint_in_limits: assert property (@(posedge clk) disable iff (rst)
    (advance && (limit_low <= limit_high)) |->
      ((setpoint_next >= limit_low) && (setpoint_next <= limit_high)))
    else $error("setpoint outside limits");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("transfer into result register lost");

endmodule
